// ===== src/xor_basis_rank_macros.svh =====
// ---------------------------------------------------------------------------
// xor_basis_rank_macros.svh
// Assertion macros used by the xor_basis_rank RTL.
// ---------------------------------------------------------------------------
`ifndef XOR_BASIS_RANK_MACROS_SVH
`define XOR_BASIS_RANK_MACROS_SVH

// Same-cycle implication, checked out of reset
`define XBR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("xor_basis_rank: assertion failed");

// Next-cycle implication, checked out of reset
`define XBR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("xor_basis_rank: assertion failed");

`endif

// ===== src/xbr_pkg.sv =====
// ---------------------------------------------------------------------------
// xbr_pkg
// Types and constants for the GF(2) basis rank block.
// ---------------------------------------------------------------------------
package xbr_pkg;

    // Field widths of the result transaction
    localparam int RANK_W  = 6;
    localparam int COUNT_W = 33;
    localparam int VALUE_W = 32;

    // Rank can never exceed the input word width
    localparam logic [RANK_W-1:0] RANK_MAX = 6'd32;

    // Control that travels down the cell chain next to the word
    typedef struct packed {
        logic valid;     // a word occupies this slot
        logic last;      // word closes its set
        logic inserted;  // word already became a basis vector
    } xbr_flags_t;

endpackage

// ===== src/xbr_cell.sv =====
// ---------------------------------------------------------------------------
// xbr_cell
// One chain cell: owns the basis vector whose leading bit is BIT.
// ---------------------------------------------------------------------------
module xbr_cell #(
    parameter int WORD_BITS = 32,
    parameter int BIT       = 31
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    advance,
    input  logic [WORD_BITS-1:0]    word_in,
    input  xbr_pkg::xbr_flags_t     flags_in,
    output logic [WORD_BITS-1:0]    word_out,
    output xbr_pkg::xbr_flags_t     flags_out
);
    import xbr_pkg::*;

    logic [WORD_BITS-1:0] vec_reg;
    logic [WORD_BITS-1:0] vec_next;
    logic                 present_reg;
    logic                 present_next;
    logic [WORD_BITS-1:0] word_reg;
    logic [WORD_BITS-1:0] word_next;
    xbr_flags_t           flags_reg;
    xbr_flags_t           flags_next;

    // Reduce against the stored vector or take the word as the new one
    always_comb
    begin
        vec_next     = vec_reg;
        present_next = present_reg;
        word_next    = word_in;
        flags_next   = flags_in;
        if (flags_in.valid && !flags_in.inserted && word_in[BIT])
        begin
            if (present_reg)
            begin
                word_next = word_in ^ vec_reg;
            end
            else
            begin
                vec_next            = word_in;
                present_next        = 1'b1;
                flags_next.inserted = 1'b1;
            end
        end
        // End of set: this cell returns to empty once the word has passed
        if (flags_in.valid && flags_in.last)
        begin
            present_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg <= 1'b0;
            flags_reg   <= '0;
        end
        else if (advance)
        begin
            present_reg <= present_next;
            flags_reg   <= flags_next;
        end
    end

    // Payload, no reset; vector is read only while present
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            vec_reg  <= vec_next;
            word_reg <= word_next;
        end
    end

    assign word_out  = word_reg;
    assign flags_out = flags_reg;

endmodule

// ===== src/xor_basis_rank.sv =====
// ---------------------------------------------------------------------------
// xor_basis_rank
// Streaming GF(2) linear basis: rank and 2^rank for each word of a set.
// ---------------------------------------------------------------------------
//  channel | signals                              | direction
//  --------+--------------------------------------+----------
//  in      | in_valid/in_ready, value, last_of_set | sink
//  out     | out_valid/out_ready, rank,            | source
//          | distinct_xor_count, set_done          |
//
// One transaction per cycle sustained while the output is not stalled; the path is
// the chain of WORD_BITS cells, one per leading bit, plus the output register.
// Reset empties every cell and the running rank; no clearing pass is needed.
// A stalled output freezes the whole chain; in_ready follows that stall.
// last_of_set empties each cell as the flagged word leaves it.
// ---------------------------------------------------------------------------
`include "xor_basis_rank_macros.svh"

module xor_basis_rank #(
    parameter int WORD_BITS = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [xbr_pkg::VALUE_W-1:0]  value,
    input  logic                         last_of_set,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [xbr_pkg::RANK_W-1:0]   rank,
    output logic [xbr_pkg::COUNT_W-1:0]  distinct_xor_count,
    output logic                         set_done
);
    import xbr_pkg::*;

    logic [WORD_BITS-1:0] word_chain [0:WORD_BITS];
    xbr_flags_t           flags_chain [0:WORD_BITS];
    logic                 advance;
    logic                 load;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [RANK_W-1:0]    rank_reg;
    logic [RANK_W-1:0]    rank_next;
    logic [RANK_W-1:0]    rank_new;
    logic [RANK_W-1:0]    rank_out_reg;
    logic [COUNT_W-1:0]   count_out_reg;
    logic                 done_out_reg;

    // Whole chain moves when the output register can take a word
    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = advance;

    // Fit the input word to the chain width
    generate
        if (WORD_BITS > VALUE_W)
        begin : g_wide
            assign word_chain[0] = {{(WORD_BITS-VALUE_W){1'b0}}, value};
        end
        else
        begin : g_narrow
            assign word_chain[0] = value[WORD_BITS-1:0];
        end
    endgenerate

    // Control entering the first cell
    assign flags_chain[0] = '{valid: in_valid, last: last_of_set, inserted: 1'b0};

    // Cell chain, highest leading bit first
    generate
        for (genvar i = 0; i < WORD_BITS; i++)
        begin : g_cell
            xbr_cell #(
                .WORD_BITS (WORD_BITS),
                .BIT       (WORD_BITS - 1 - i)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .advance   (advance),
                .word_in   (word_chain[i]),
                .flags_in  (flags_chain[i]),
                .word_out  (word_chain[i+1]),
                .flags_out (flags_chain[i+1])
            );
        end
    endgenerate

    // Running rank and output register
    assign load     = advance && flags_chain[WORD_BITS].valid;
    assign rank_new = rank_reg + {{(RANK_W-1){1'b0}}, flags_chain[WORD_BITS].inserted};

    always_comb
    begin
        rank_next      = rank_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            rank_next      = flags_chain[WORD_BITS].last ? '0 : rank_new;
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            rank_reg      <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            rank_reg      <= rank_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rank_out_reg  <= rank_new;
            count_out_reg <= {{(COUNT_W-1){1'b0}}, 1'b1} << rank_new;
            done_out_reg  <= flags_chain[WORD_BITS].last;
        end
    end

    assign out_valid          = out_valid_reg;
    assign rank               = rank_out_reg;
    assign distinct_xor_count = count_out_reg;
    assign set_done           = done_out_reg;

    // Checks
    `XBR_ASSERT_NOW(a_count_onehot, out_valid, $onehot(distinct_xor_count))
    `XBR_ASSERT_NOW(a_rank_bound, out_valid, rank <= RANK_MAX)
    `XBR_ASSERT_NEXT(a_rank_clear, load && flags_chain[WORD_BITS].last, rank_reg == '0)
    `XBR_ASSERT_NEXT(a_rank_carry, load && !flags_chain[WORD_BITS].last, rank_reg == rank)

endmodule
